[hw/rtl/lrt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lrt_pkg;

	localparam int ROW_W       = 10;
	localparam int ROW_COUNT_W = 11;
	localparam int STEPS_W     = 10;
	localparam int CMD_W       = 3;
	localparam int STATUS_W    = 2;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 11;

	localparam logic [CMD_W-1:0] CMD_INIT    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_UP      = 3'd1;
	localparam logic [CMD_W-1:0] CMD_DOWN    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DELETE  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_RESTORE = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MOVE_END = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_REFUSED  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_ROW = 1'b1;

	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [STEPS_W-1:0] steps;
		logic [ROW_W-1:0]   query_row;
	} request_t;

	typedef struct packed {
		logic [ROW_W-1:0]    cursor_row;
		logic                query_present;
		logic [STATUS_W-1:0] status;
	} result_t;

	typedef struct packed {
		logic live;
		logic prev;
		logic next;
	} link_wmask_t;

endpackage

`default_nettype wire

[hw/rtl/lrt_link_mem.sv]
`timescale 1ns / 1ps
`default_nettype none

module lrt_link_mem #(
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH),
	localparam int LW = $clog2(DEPTH + 1)
) (
	input  wire logic                clk,
	input  wire lrt_pkg::link_wmask_t wr_mask,
	input  wire logic [AW-1:0]       wr_addr,
	input  wire logic [LW-1:0]       wr_next,
	input  wire logic [LW-1:0]       wr_prev,
	input  wire logic                wr_live,
	input  wire logic [AW-1:0]       rd_a_addr,
	output logic      [LW-1:0]       rd_a_next,
	output logic      [LW-1:0]       rd_a_prev,
	input  wire logic [AW-1:0]       rd_b_addr,
	output logic                     rd_b_live
);

	typedef struct packed {
		logic          live;
		logic [LW-1:0] prev;
		logic [LW-1:0] next;
	} word_t;

	word_t mem [DEPTH];
	word_t rd_a_q;
	logic  rd_b_live_q;

	always_ff @(posedge clk) begin
		if (wr_mask.next) begin
			mem[wr_addr].next <= wr_next;
		end
		if (wr_mask.prev) begin
			mem[wr_addr].prev <= wr_prev;
		end
		if (wr_mask.live) begin
			mem[wr_addr].live <= wr_live;
		end
		rd_a_q      <= mem[rd_a_addr];
		rd_b_live_q <= mem[rd_b_addr].live;
	end

	assign rd_a_next = rd_a_q.next;
	assign rd_a_prev = rd_a_q.prev;
	assign rd_b_live = rd_b_live_q;

endmodule

`default_nettype wire

[hw/rtl/lrt_stack_mem.sv]
`timescale 1ns / 1ps
`default_nettype none

module lrt_stack_mem #(
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [AW-1:0] wr_data,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [AW-1:0] rd_data
);

	logic [AW-1:0] mem [DEPTH];
	logic [AW-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

[hw/rtl/linked_row_table_with_undo.sv]
`timescale 1ns / 1ps
`default_nettype none

// Row table kept as a doubly linked list, with a cursor and an undo stack of deleted rows.
// A command transaction is accepted on a rising edge with start high and busy low.
// Each command yields one result on the result port, marked by done for exactly one cycle;
// the receiver cannot stall, and the next command may be accepted in that same cycle.
// Registers row_count and start_row are written through the cfg channel; the user must do so
// only while the block is idle, as the block itself does not enforce it. Steps per command,
// from acceptance until busy falls, shaped by the single write port and registered read of
// the link memory; every command ends with a query step and a result step:
//   init: one link-memory row written per cycle, covering every row.
//   up/down: a read, then one link followed per cycle, stopping early at an end; skipped when steps is zero.
//   delete: read, check, unlink at prev and next; refused after the check.
//   restore: stack read, link read, relink; skipped when the stack is empty. other codes: none.
// The result strobe rises on the same edge at which busy falls.
// After reset the block sweeps the presence bit of every row to one with busy high;
// configuration writes are taken during that sweep. Links are defined only after the first init.

module linked_row_table_with_undo #(
	parameter int MAX_ROWS = 1024
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire lrt_pkg::request_t                   request,
	output logic                                     done,
	output lrt_pkg::result_t                         result,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [lrt_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [lrt_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int IDX_W  = $clog2(MAX_ROWS);
	localparam int LINK_W = $clog2(MAX_ROWS + 1);
	localparam int CMP_W  = (LINK_W > lrt_pkg::ROW_COUNT_W) ? LINK_W : lrt_pkg::ROW_COUNT_W;
	localparam logic [LINK_W-1:0] NIL      = LINK_W'(MAX_ROWS);
	localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(MAX_ROWS - 1);

	typedef enum logic [14:0] {
		S_CLEAR    = 15'b000000000000001,
		S_IDLE     = 15'b000000000000010,
		S_INIT     = 15'b000000000000100,
		S_WALK_RD  = 15'b000000000001000,
		S_WALK     = 15'b000000000010000,
		S_DEL_RD   = 15'b000000000100000,
		S_DEL_CHK  = 15'b000000001000000,
		S_DEL_P    = 15'b000000010000000,
		S_DEL_N    = 15'b000000100000000,
		S_RES_RD   = 15'b000001000000000,
		S_RES_LINK = 15'b000010000000000,
		S_RES_P    = 15'b000100000000000,
		S_RES_N    = 15'b001000000000000,
		S_QUERY    = 15'b010000000000000,
		S_DONE     = 15'b100000000000000
	} state_t;

	function automatic logic has_link(input logic [LINK_W-1:0] v);
		return v < NIL;
	endfunction

	state_t                             state_q;
	logic [lrt_pkg::ROW_COUNT_W-1:0]    row_count_q;
	logic [lrt_pkg::ROW_W-1:0]          start_row_q;
	logic [IDX_W-1:0]                   sweep_q;
	logic [IDX_W-1:0]                   cursor_q;
	logic [LINK_W-1:0]                  stack_cnt_q;
	logic [LINK_W-1:0]                  cnt_q;
	logic [lrt_pkg::STEPS_W-1:0]        steps_q;
	logic                               dir_up_q;
	logic [IDX_W-1:0]                   query_idx_q;
	logic                               q_in_range_q;
	logic [lrt_pkg::STATUS_W-1:0]       status_q;
	logic [LINK_W-1:0]                  p_q;
	logic [LINK_W-1:0]                  nx_q;
	logic [IDX_W-1:0]                   r_q;
	logic                               done_q;
	lrt_pkg::result_t                   result_q;

	lrt_pkg::link_wmask_t wmask;
	logic [IDX_W-1:0]     waddr;
	logic [LINK_W-1:0]    wnext;
	logic [LINK_W-1:0]    wprev;
	logic                 wlive;
	logic [IDX_W-1:0]     ra_addr;
	logic [LINK_W-1:0]    rd_next;
	logic [LINK_W-1:0]    rd_prev;
	logic                 rd_b_live;
	logic                 stk_we;
	logic [IDX_W-1:0]     stk_waddr;
	logic [IDX_W-1:0]     stk_raddr;
	logic [IDX_W-1:0]     stk_rdata;

	logic [CMP_W-1:0]     rc_ext;
	logic [LINK_W-1:0]    cnt_d;
	logic [IDX_W-1:0]     start_cl;
	logic [LINK_W-1:0]    sw_ext;
	logic [LINK_W-1:0]    sw_inc;
	logic [LINK_W-1:0]    init_next;
	logic [LINK_W-1:0]    init_prev;
	logic                 init_live;
	logic [LINK_W-1:0]    walk_to;
	logic                 del_refuse;

	assign rc_ext = CMP_W'(row_count_q);
	assign cnt_d = (rc_ext == '0) ? LINK_W'(1) :
		(rc_ext > CMP_W'(MAX_ROWS)) ? NIL : LINK_W'(rc_ext);
	assign start_cl = (CMP_W'(start_row_q) < CMP_W'(cnt_q)) ? IDX_W'(start_row_q) :
		IDX_W'(cnt_q - LINK_W'(1));

	assign sw_ext    = LINK_W'(sweep_q);
	assign sw_inc    = sw_ext + LINK_W'(1);
	assign init_prev = (sweep_q == '0) ? NIL : sw_ext - LINK_W'(1);
	assign init_next = (sw_inc < cnt_q) ? sw_inc : NIL;
	assign init_live = sw_ext < cnt_q;

	assign walk_to    = dir_up_q ? rd_prev : rd_next;
	assign del_refuse = (!has_link(rd_prev) && !has_link(rd_next)) || (stack_cnt_q >= NIL);

	always_comb begin
		wmask     = '0;
		waddr     = cursor_q;
		wnext     = nx_q;
		wprev     = p_q;
		wlive     = 1'b0;
		ra_addr   = cursor_q;
		stk_we    = 1'b0;
		stk_waddr = IDX_W'(stack_cnt_q);
		stk_raddr = IDX_W'(stack_cnt_q - LINK_W'(1));
		case (state_q)
			S_CLEAR: begin
				wmask.live = 1'b1;
				waddr      = sweep_q;
				wlive      = 1'b1;
			end
			S_INIT: begin
				wmask = '1;
				waddr = sweep_q;
				wnext = init_next;
				wprev = init_prev;
				wlive = init_live;
			end
			S_WALK: begin
				ra_addr = IDX_W'(walk_to);
			end
			S_DEL_CHK: begin
				if (!del_refuse) begin
					wmask.live = 1'b1;
					wlive      = 1'b0;
					stk_we     = 1'b1;
				end
			end
			S_DEL_P: begin
				wmask.next = has_link(p_q);
				waddr      = IDX_W'(p_q);
				wnext      = nx_q;
			end
			S_DEL_N: begin
				wmask.prev = has_link(nx_q);
				waddr      = IDX_W'(nx_q);
				wprev      = p_q;
			end
			S_RES_RD: begin
				ra_addr = stk_rdata;
			end
			S_RES_LINK: begin
				wmask.live = 1'b1;
				waddr      = r_q;
				wlive      = 1'b1;
			end
			S_RES_P: begin
				wmask.next = has_link(p_q);
				waddr      = IDX_W'(p_q);
				wnext      = LINK_W'(r_q);
			end
			S_RES_N: begin
				wmask.prev = has_link(nx_q);
				waddr      = IDX_W'(nx_q);
				wprev      = LINK_W'(r_q);
			end
			default: begin
			end
		endcase
	end

	lrt_link_mem #(
		.DEPTH(MAX_ROWS)
	) u_link_mem (
		.clk      (clk),
		.wr_mask  (wmask),
		.wr_addr  (waddr),
		.wr_next  (wnext),
		.wr_prev  (wprev),
		.wr_live  (wlive),
		.rd_a_addr(ra_addr),
		.rd_a_next(rd_next),
		.rd_a_prev(rd_prev),
		.rd_b_addr(query_idx_q),
		.rd_b_live(rd_b_live)
	);

	lrt_stack_mem #(
		.DEPTH(MAX_ROWS)
	) u_stack_mem (
		.clk    (clk),
		.wr_en  (stk_we),
		.wr_addr(stk_waddr),
		.wr_data(cursor_q),
		.rd_addr(stk_raddr),
		.rd_data(stk_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= lrt_pkg::ROW_COUNT_W'(1024);
			start_row_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				lrt_pkg::CFG_ROW_COUNT: row_count_q <= cfg_data;
				lrt_pkg::CFG_START_ROW: start_row_q <= cfg_data[lrt_pkg::ROW_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			sweep_q     <= '0;
			cursor_q    <= '0;
			stack_cnt_q <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					sweep_q <= sweep_q + IDX_W'(1);
					if (sweep_q == LAST_IDX) begin
						sweep_q <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						status_q     <= lrt_pkg::ST_OK;
						query_idx_q  <= IDX_W'(request.query_row);
						q_in_range_q <= CMP_W'(request.query_row) < CMP_W'(MAX_ROWS);
						dir_up_q     <= request.command == lrt_pkg::CMD_UP;
						steps_q      <= request.steps;
						case (request.command)
							lrt_pkg::CMD_INIT: begin
								cnt_q   <= cnt_d;
								sweep_q <= '0;
								state_q <= S_INIT;
							end
							lrt_pkg::CMD_UP, lrt_pkg::CMD_DOWN: begin
								state_q <= (request.steps == '0) ? S_QUERY : S_WALK_RD;
							end
							lrt_pkg::CMD_DELETE: begin
								state_q <= S_DEL_RD;
							end
							lrt_pkg::CMD_RESTORE: begin
								if (stack_cnt_q == '0) begin
									status_q <= lrt_pkg::ST_EMPTY;
									state_q  <= S_QUERY;
								end else begin
									stack_cnt_q <= stack_cnt_q - LINK_W'(1);
									state_q     <= S_RES_RD;
								end
							end
							default: begin
								state_q <= S_QUERY;
							end
						endcase
					end
				end
				S_INIT: begin
					sweep_q <= sweep_q + IDX_W'(1);
					if (sweep_q == LAST_IDX) begin
						sweep_q     <= '0;
						stack_cnt_q <= '0;
						cursor_q    <= start_cl;
						state_q     <= S_QUERY;
					end
				end
				S_WALK_RD: begin
					state_q <= S_WALK;
				end
				S_WALK: begin
					if (!has_link(walk_to)) begin
						status_q <= lrt_pkg::ST_MOVE_END;
						state_q  <= S_QUERY;
					end else begin
						cursor_q <= IDX_W'(walk_to);
						steps_q  <= steps_q - lrt_pkg::STEPS_W'(1);
						if (steps_q == lrt_pkg::STEPS_W'(1)) begin
							state_q <= S_QUERY;
						end
					end
				end
				S_DEL_RD: begin
					state_q <= S_DEL_CHK;
				end
				S_DEL_CHK: begin
					p_q  <= rd_prev;
					nx_q <= rd_next;
					if (del_refuse) begin
						status_q <= lrt_pkg::ST_REFUSED;
						state_q  <= S_QUERY;
					end else begin
						stack_cnt_q <= stack_cnt_q + LINK_W'(1);
						state_q     <= S_DEL_P;
					end
				end
				S_DEL_P: begin
					state_q <= S_DEL_N;
				end
				S_DEL_N: begin
					cursor_q <= has_link(nx_q) ? IDX_W'(nx_q) : IDX_W'(p_q);
					state_q  <= S_QUERY;
				end
				S_RES_RD: begin
					r_q     <= stk_rdata;
					state_q <= S_RES_LINK;
				end
				S_RES_LINK: begin
					p_q     <= rd_prev;
					nx_q    <= rd_next;
					state_q <= S_RES_P;
				end
				S_RES_P: begin
					state_q <= S_RES_N;
				end
				S_RES_N: begin
					state_q <= S_QUERY;
				end
				S_QUERY: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					done_q                 <= 1'b1;
					result_q.cursor_row    <= lrt_pkg::ROW_W'(cursor_q);
					result_q.query_present <= q_in_range_q & rd_b_live;
					result_q.status        <= status_q;
					state_q                <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy      = state_q != S_IDLE;
	assign done      = done_q;
	assign result    = result_q;
	assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

[hw/rtl/lrt_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module lrt_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("Accepted command transaction did not raise busy.");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("Result strobe while a command is still in progress.");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("Result strobe without a preceding command.");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("Result strobe held for more than one cycle.");

endmodule

bind linked_row_table_with_undo lrt_checker u_lrt_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done)
);

`default_nettype wire
